FILE: hw/rtl/ac3hp_pkg.sv
`timescale 1ns / 1ps
package ac3hp_pkg;

  localparam int HDR_BYTES = 8;
  localparam int HDR_BITS  = HDR_BYTES * 8;

  localparam logic [15:0] SYNC_WORD          = 16'h0B77;
  localparam logic [1:0]  STRMTYP_RESERVED   = 2'd3;
  localparam logic [1:0]  FSCOD_RESERVED     = 2'd3;
  localparam logic [13:0] EAC3_FRAME_MIN     = 14'd8;
  localparam logic [13:0] EAC3_FRAME_MAX     = 14'd8192;
  localparam logic [4:0]  EAC3_BSID_MIN      = 5'd11;
  localparam logic [4:0]  EAC3_BSID_MAX      = 5'd16;
  localparam logic [5:0]  AC3_FRMSIZECOD_LIM = 6'd38;
  localparam logic [4:0]  AC3_BSID_MAX       = 5'd10;
  localparam logic [5:0]  AC3_LFEON_BASE     = 6'd51;

  localparam logic [2:0]  ACMOD_MONO   = 3'd1;
  localparam logic [2:0]  ACMOD_STEREO = 3'd2;

  typedef struct packed {
    logic                win_full;
    logic [HDR_BITS-1:0] hdr;
  } ac3hp_entry_t;

  typedef struct packed {
    logic         valid;
    ac3hp_entry_t entry;
  } ac3hp_push_t;

  function automatic logic [2:0] main_channels(input logic [2:0] acmod);
    logic [2:0] ch;
    case (acmod)
      3'd0:    ch = 3'd2;
      3'd1:    ch = 3'd1;
      3'd2:    ch = 3'd2;
      3'd3:    ch = 3'd3;
      3'd4:    ch = 3'd3;
      3'd5:    ch = 3'd4;
      3'd6:    ch = 3'd4;
      default: ch = 3'd5;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/ac3hp_front.sv
`timescale 1ns / 1ps
module ac3hp_front
  import ac3hp_pkg::*;
#(
  parameter int WINDOW_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  stream_byte,
  input  logic        restart,
  output ac3hp_push_t push
);

  localparam int FILL_W   = $clog2(WINDOW_BYTES + 1);
  localparam int WIN_BITS = WINDOW_BYTES * 8;

  logic [7:0]        window_r   [WINDOW_BYTES];
  logic [7:0]        window_nxt [WINDOW_BYTES];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_nxt;
  logic [WIN_BITS-1:0] win_flat;
  logic [WIN_BITS+HDR_BITS-1:0] win_pad;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      window_nxt[i] = window_r[i+1];
    end
    window_nxt[WINDOW_BYTES-1] = stream_byte;
  end

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      win_flat[WIN_BITS-1-8*i -: 8] = window_nxt[i];
    end
  end

  assign win_pad   = {win_flat, {HDR_BITS{1'b0}}};
  assign fill_base = restart ? '0 : fill_r;
  assign fill_nxt  = (fill_base < FILL_W'(WINDOW_BYTES)) ? fill_base + 1'b1 : fill_base;

  assign push.valid          = accept;
  assign push.entry.win_full = (fill_nxt == FILL_W'(WINDOW_BYTES));
  assign push.entry.hdr      = win_pad[WIN_BITS+HDR_BITS-1 -: HDR_BITS];

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        window_r[i] <= window_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: hw/rtl/ac3hp_queue.sv
`timescale 1ns / 1ps
module ac3hp_queue
  import ac3hp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ac3hp_push_t  push,
  output logic         full,
  output logic         head_valid,
  output ac3hp_entry_t head,
  input  logic         pop
);

  ac3hp_entry_t mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;
  logic         do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/ac3hp_back.sv
`timescale 1ns / 1ps
module ac3hp_back
  import ac3hp_pkg::*;
#(
  parameter int WINDOW_BYTES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         eac3_mode,
  input  logic         head_valid,
  input  ac3hp_entry_t head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         header_found,
  output logic [2:0]   channel_count
);

  localparam int WIN_BITS = WINDOW_BYTES * 8;

  logic [HDR_BITS-1:0] h;
  logic        sync_ok;

  logic [1:0]  e_strm;
  logic [2:0]  e_subid;
  logic [10:0] e_frmsiz;
  logic [13:0] e_fsize;
  logic [1:0]  e_fscod;
  logic [1:0]  e_next2;
  logic [2:0]  e_acmod;
  logic        e_lfeon;
  logic [4:0]  e_bsid;
  logic        e_ok;

  logic [1:0]  a_fscod;
  logic [5:0]  a_frmsizecod;
  logic [4:0]  a_bsid;
  logic [2:0]  a_acmod;
  logic [2:0]  a_skip;
  logic [5:0]  a_lfe_pos;
  logic        a_lfeon;
  logic        a_ok;

  logic        found;
  logic [2:0]  ch;

  logic        out_valid_r;
  logic        found_r;
  logic [2:0]  ch_r;

  assign h       = head.hdr;
  assign sync_ok = (h[63:48] == SYNC_WORD);

  assign e_strm   = h[47:46];
  assign e_subid  = h[45:43];
  assign e_frmsiz = h[42:32];
  assign e_fsize  = (14'(e_frmsiz) + 14'd1) << 1;
  assign e_fscod  = h[31:30];
  assign e_next2  = h[29:28];
  assign e_acmod  = h[27:25];
  assign e_lfeon  = h[24];
  assign e_bsid   = h[23:19];

  assign e_ok = sync_ok && (e_strm != STRMTYP_RESERVED)
             && (e_fsize >= EAC3_FRAME_MIN) && (e_fsize <= EAC3_FRAME_MAX)
             && !((e_fscod == FSCOD_RESERVED) && (e_next2 == FSCOD_RESERVED))
             && (e_bsid >= EAC3_BSID_MIN) && (e_bsid <= EAC3_BSID_MAX)
             && (e_strm == 2'd0) && (e_subid == 3'd0);

  assign a_fscod      = h[31:30];
  assign a_frmsizecod = h[29:24];
  assign a_bsid       = h[23:19];
  assign a_acmod      = h[15:13];

  always_comb begin
    a_skip = 3'd0;
    if (a_acmod[0] && (a_acmod != ACMOD_MONO)) begin
      a_skip = a_skip + 3'd2;
    end
    if (a_acmod[2]) begin
      a_skip = a_skip + 3'd2;
    end
    if (a_acmod == ACMOD_STEREO) begin
      a_skip = a_skip + 3'd2;
    end
  end

  assign a_lfe_pos = AC3_LFEON_BASE + 6'(a_skip);
  assign a_lfeon   = h[4'd12 - 4'(a_skip)];

  assign a_ok = sync_ok && (a_fscod != FSCOD_RESERVED)
             && (a_frmsizecod < AC3_FRMSIZECOD_LIM) && (a_bsid <= AC3_BSID_MAX)
             && (32'(a_lfe_pos) < WIN_BITS);

  always_comb begin
    if (eac3_mode) begin
      found = head.win_full && e_ok;
      ch    = main_channels(e_acmod) + 3'(e_lfeon);
    end else begin
      found = head.win_full && a_ok;
      ch    = main_channels(a_acmod) + 3'(a_lfeon);
    end
    if (!found) begin
      ch = 3'd0;
    end
  end

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      found_r <= found;
      ch_r    <= ch;
    end
  end

  assign out_valid     = out_valid_r;
  assign header_found  = found_r;
  assign channel_count = ch_r;

endmodule

FILE: hw/rtl/ac3_eac3_header_channel_probe_core.sv
`timescale 1ns / 1ps
// AC-3 / E-AC-3 sync header probe. Takes one elementary-stream byte per
// transaction into a sliding window of the last WINDOW_BYTES bytes and returns
// one result per byte: header_found (out_tuser) and channel_count (acmod
// channels plus lfeon, out_tdata) for a header starting at the window's oldest
// byte, once the window has filled since reset or the last restart (in_tuser).
// cfg_wr_data selects E-AC-3 (1) or AC-3 (0) parsing; write it only while idle.
// One byte is taken per cycle while in_tready is high. A byte's result passes
// through window update and queue write on the accepting edge, then the
// header parse into the output register. A two-entry queue sits between window
// and parser, so in_tready drops only after out_tready has been low long enough
// to fill it.
module ac3_eac3_header_channel_probe_core
  import ac3hp_pkg::*;
#(
  parameter int WINDOW_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] stream_byte
  input  logic       in_tuser,   // [0] restart
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] channel_count, [7:3] zero
  output logic       out_tuser,  // [0] header_found
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic         eac3_mode_r;
  logic         in_accept;
  logic         q_full;
  logic         q_head_valid;
  logic         q_pop;
  ac3hp_entry_t q_head;
  ac3hp_push_t  q_push;
  logic [2:0]   channel_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eac3_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      eac3_mode_r <= cfg_wr_data;
    end
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  ac3hp_front #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .stream_byte (in_tdata),
    .restart     (in_tuser),
    .push        (q_push)
  );

  ac3hp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  ac3hp_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .eac3_mode     (eac3_mode_r),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .header_found  (out_tuser),
    .channel_count (channel_count)
  );

  assign out_tdata = {5'd0, channel_count};

endmodule

FILE: sim/tb_ac3_eac3_header_channel_probe_core.sv
`timescale 1ns / 1ps
module tb_ac3_eac3_header_channel_probe_core;
  import ac3hp_pkg::*;

  localparam int WIN = 16;
  localparam logic [2:0] CHAN_TAB [8] = '{3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5};

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       restart;
  } stream_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] channels;
  } probe_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;   // [7:0] stream_byte
  logic       in_tuser = 1'b0;   // [0] restart
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [2:0] channel_count, [7:3] zero
  logic       out_tuser;         // [0] header_found
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  stream_item_t  pending_bytes[$];
  probe_result_t expected_results[$];

  logic [7:0] win_q [WIN];
  int         win_fill = 0;
  logic       eac3_sel = 1'b0;

  int   accepted_cnt = 0;
  int   error_cnt = 0;
  int   stall_left = 0;
  logic stall_done = 1'b0;
  wire  calm = (accepted_cnt >= 300) && (accepted_cnt < 420);

  ac3_eac3_header_channel_probe_core #(.WINDOW_BYTES(WIN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // msb-first field read, position 0 is the top bit of the oldest byte
  function automatic logic [15:0] grab(input int pos, input int n);
    logic [15:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v = {v[14:0], win_q[(pos + k) / 8][7 - ((pos + k) % 8)]};
    return v;
  endfunction

  function automatic logic [2:0] eac3_channels();
    logic [1:0] strm;
    logic [2:0] subid;
    int         fsize;
    logic [1:0] fscod;
    logic [1:0] fscod2;
    logic [2:0] acmod;
    logic [4:0] bsid;
    strm   = 2'(grab(16, 2));
    subid  = 3'(grab(18, 3));
    fsize  = (int'(grab(21, 11)) + 1) * 2;
    fscod  = 2'(grab(32, 2));
    fscod2 = 2'(grab(34, 2));
    acmod  = 3'(grab(36, 3));
    bsid   = 5'(grab(40, 5));
    if (strm == STRMTYP_RESERVED || fsize < int'(EAC3_FRAME_MIN) ||
        fsize > int'(EAC3_FRAME_MAX)) return 3'd0;
    if (fscod == FSCOD_RESERVED && fscod2 == FSCOD_RESERVED) return 3'd0;
    if (bsid < EAC3_BSID_MIN || bsid > EAC3_BSID_MAX || strm != 2'd0 || subid != 3'd0)
      return 3'd0;
    return CHAN_TAB[acmod] + 3'(grab(39, 1));
  endfunction

  function automatic logic [2:0] ac3_channels();
    logic [1:0] fscod;
    logic [5:0] frmsizecod;
    logic [4:0] bsid;
    logic [2:0] acmod;
    int         p;
    fscod      = 2'(grab(32, 2));
    frmsizecod = 6'(grab(34, 6));
    bsid       = 5'(grab(40, 5));
    acmod      = 3'(grab(48, 3));
    if (fscod == FSCOD_RESERVED || frmsizecod >= AC3_FRMSIZECOD_LIM || bsid > AC3_BSID_MAX)
      return 3'd0;
    // mix level fields ahead of lfeon
    p = 51;
    if (acmod[0] && acmod != ACMOD_MONO) p += 2;
    if (acmod[2]) p += 2;
    if (acmod == ACMOD_STEREO) p += 2;
    return CHAN_TAB[acmod] + 3'(grab(p, 1));
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic rs);
    probe_result_t r;
    if (rs) win_fill = 0;
    if (win_fill < WIN) begin
      win_q[win_fill] = b;
      win_fill++;
    end else begin
      for (int i = 0; i < WIN - 1; i++) win_q[i] = win_q[i + 1];
      win_q[WIN - 1] = b;
    end
    r.channels = 3'd0;
    if (win_fill >= WIN && win_q[0] == SYNC_WORD[15:8] && win_q[1] == SYNC_WORD[7:0])
      r.channels = eac3_sel ? eac3_channels() : ac3_channels();
    r.found = (r.channels != 3'd0);
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_cnt++;
  endtask

  task automatic add_item(input logic [7:0] b, input logic rs);
    stream_item_t it;
    it.stream_byte = b;
    it.restart = rs;
    pending_bytes.push_back(it);
  endtask

  task automatic add_frame(input logic [127:0] f, input int len, input logic rs);
    for (int k = 0; k < len; k++) add_item(f[127 - 8 * k -: 8], rs && (k == 0));
  endtask

  function automatic logic [127:0] ac3_frame();
    logic [127:0] f;
    f = {$urandom, $urandom, $urandom, $urandom};
    f[127:112] = SYNC_WORD;
    if ($urandom_range(9) != 0) f[95:94] = 2'($urandom_range(2));
    if ($urandom_range(9) != 0) f[93:88] = 6'($urandom_range(37));
    if ($urandom_range(9) != 0) f[87:83] = 5'($urandom_range(10));
    return f;
  endfunction

  function automatic logic [127:0] eac3_frame();
    logic [127:0] f;
    f = {$urandom, $urandom, $urandom, $urandom};
    f[127:112] = SYNC_WORD;
    if ($urandom_range(7) != 0) f[111:110] = 2'd0;
    if ($urandom_range(7) != 0) f[109:107] = 3'd0;
    if ($urandom_range(9) == 0) f[106:96] = 11'($urandom_range(4));
    if ($urandom_range(9) != 0) f[87:83] = 5'(11 + $urandom_range(5));
    return f;
  endfunction

  task automatic queue_random(input int count, input logic eac3);
    int   n;
    int   r;
    int   len;
    logic rs;
    n = 0;
    rs = 1'b0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        if (eac3 ^ ($urandom_range(9) == 0)) add_frame(eac3_frame(), 16, rs);
        else add_frame(ac3_frame(), 16, rs);
        rs = 1'b0;
        n += 16;
      end else if (r < 85) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          add_item(8'($urandom), rs);
          rs = 1'b0;
        end
        n += len;
      end else if (r < 92) begin
        rs = 1'b1;
      end else begin
        // broken header cut short by a restart or more noise
        len = $urandom_range(2, 10);
        add_frame(eac3 ? eac3_frame() : ac3_frame(), len, rs);
        rs = ($urandom_range(1) == 0);
        n += len;
      end
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eac3_sel = v;
  endtask

  always @(posedge clk) begin : drive
    stream_item_t it;
    logic         take;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      take = in_tvalid && in_tready;
      if (take) begin
        take_byte(in_tdata, in_tuser);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || take) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          it = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.stream_byte;
          in_tuser <= it.restart;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!stall_done && accepted_cnt >= 120) begin
      stall_left <= 60;
      stall_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin : check
    probe_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, channel_count", out_tdata[2:0], 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.found)
          report_mismatch("header_found", out_tuser, want.found);
        if (out_tdata[2:0] !== want.channels)
          report_mismatch("channel_count", out_tdata[2:0], want.channels);
      end
    end
  end

  initial begin
    for (int i = 0; i < WIN; i++) win_q[i] = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ac3, max frmsizecod, max bsid, 3/2 with lfe
    add_item(8'h0B, 1'b1);
    add_item(8'h77, 1'b0);
    add_item(8'h12, 1'b0);
    add_item(8'h34, 1'b0);
    add_item(8'h25, 1'b0);
    add_item(8'h50, 1'b0);
    add_item(8'hE1, 1'b0);
    for (int k = 0; k < 9; k++) add_item((k % 2) ? 8'hFF : 8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h0B, 1'b1);
    add_item(8'h77, 1'b0);
    queue_random(150, 1'b0);
    drain();

    write_mode(1'b1);
    // eac3, largest frmsiz, bsid 16, stereo with lfe
    add_item(8'h0B, 1'b1);
    add_item(8'h77, 1'b0);
    add_item(8'h07, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h35, 1'b0);
    add_item(8'h80, 1'b0);
    for (int k = 0; k < 10; k++) add_item(8'($urandom), 1'b0);
    queue_random(200, 1'b1);
    drain();

    write_mode(1'b0);
    queue_random(90, 1'b0);
    drain();

    write_mode(1'b1);
    queue_random(90, 1'b1);
    drain();

    if (error_cnt == 0) begin
      $display("tb_ac3_eac3_header_channel_probe_core: done, clean");
    end else begin
      $display("tb_ac3_eac3_header_channel_probe_core: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_ac3_eac3_header_channel_probe_core: done, errors");
    $finish;
  end

endmodule
